FILE: design/power_of_two_box_downsampler_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the power-of-two box downsampler
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef POWER_OF_TWO_BOX_DOWNSAMPLER_TOP_MACROS_SVH
`define POWER_OF_TWO_BOX_DOWNSAMPLER_TOP_MACROS_SVH

// Implication that is checked only outside reset.
`define PBD_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication that is checked at every edge, reset included.
`define PBD_ASSERT_ALWAYS(name, ante, cons, msg) \
   name: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: design/pbd_pkg.sv
// ----------------------------------------------------------------------------
// Power-of-two box downsampler package
// Payload types and configuration register indexes.
// ----------------------------------------------------------------------------
package pbd_pkg;

   localparam int PIX_W       = 8;
   localparam int GEOM_W      = 13;
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SOURCE_WIDTH,
      CSR_SOURCE_HEIGHT,
      CSR_GREY_MODE
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } req_payload_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_red;
      logic [PIX_W-1:0] out_green;
      logic [PIX_W-1:0] out_blue;
      logic             last_pixel;
   } rsp_payload_type;

endpackage

FILE: design/pbd_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module pbd_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/power_of_two_box_downsampler_top.sv
// ----------------------------------------------------------------------------
// Power-of-two box downsampler
// Averages scale-by-scale blocks of a raster-order frame into one pixel each.
// ----------------------------------------------------------------------------
// Source pixels enter on the req_ channel in raster order, one transfer per
// pixel, and averaged pixels leave on the rsp_ channel. A transfer happens at
// a rising edge where valid is high and stall is low. The csr_ channel writes
// the source width, the source height and the grey mode flag; a geometry
// write picks a new scale and restarts the frame at the top-left pixel.
// The block takes one pixel per cycle while the input does not stall. Each
// transfer reads the line store; the read-modify-write stage adds the pixel
// and writes back, and the pixel that completes a block sends its result on
// to the output register. The line store is a single RAM that holds three
// channel sums per output column; it is written as the stage advances, and
// a read that hits the entry being written takes the new sum by forwarding.
// While the receiver stalls, the output register holds its result; pixels
// that finish no block keep flowing, and the input stalls only when a second
// finished result would have nowhere to go.
// Reset is synchronous and clears the pipeline, the position counters and
// the registers to a 512 by 512 color frame. The line store needs no
// clearing, since the first pixel of each block overwrites its entry.
// ----------------------------------------------------------------------------
module power_of_two_box_downsampler_top
   import pbd_pkg::*;
#(
   parameter int LIMIT_SIDE     = 512,
   parameter int MAX_SCALE_LOG2 = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   // Source pixel channel.
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   // Averaged pixel channel.
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   // Configuration write channel.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [GEOM_W-1:0]      csr_data
);

   // Each channel sum covers up to 4^MAX_SCALE_LOG2 bytes.
   localparam int SUM_W   = PIX_W + 2 * MAX_SCALE_LOG2;
   localparam int ENTRY_W = 3 * SUM_W;
   localparam int ADDR_W  = $clog2(LIMIT_SIDE);
   localparam int SHIFT_W = $clog2(MAX_SCALE_LOG2 + 1);
   localparam logic [GEOM_W:0] LIMIT_VAL = (GEOM_W + 1)'(LIMIT_SIDE);

   // Smallest shift that brings the longer side to LIMIT_SIDE or below,
   // saturating at MAX_SCALE_LOG2. The test is monotonic in the shift, so
   // the shift equals the number of shifts that still leave it too long.
   function automatic logic [SHIFT_W-1:0] pick_scale(input logic [GEOM_W-1:0] w,
                                                     input logic [GEOM_W-1:0] h);
      logic [GEOM_W-1:0]  longer;
      logic [SHIFT_W-1:0] k;
      longer = (w > h) ? w : h;
      k      = '0;
      for (int i = 0; i < MAX_SCALE_LOG2; i++) begin
         if ({1'b0, longer >> i} > LIMIT_VAL) begin
            k = k + SHIFT_W'(1);
         end
      end
      return k;
   endfunction

   // Configuration and position state.
   logic [GEOM_W-1:0]  width_ff, width_in;
   logic [GEOM_W-1:0]  height_ff, height_in;
   logic               grey_ff, grey_in;
   logic [SHIFT_W-1:0] scale_ff, scale_in;
   logic [GEOM_W-1:0]  col_ff, col_in;
   logic [GEOM_W-1:0]  row_ff, row_in;

   // Read-modify-write stage.
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_first_ff, s1_first_in;
   logic               s1_emit_ff, s1_emit_in;
   logic               s1_last_ff, s1_last_in;
   logic               s1_fwd_ff, s1_fwd_in;
   logic [ADDR_W-1:0]  s1_addr_ff, s1_addr_in;
   req_payload_type    s1_pix_ff, s1_pix_in;
   logic [ENTRY_W-1:0] fwd_data_ff, fwd_data_in;

   // Output register.
   logic               out_valid_ff, out_valid_in;
   rsp_payload_type    out_payload_ff, out_payload_in;

   // Datapath signals.
   logic               req_xfer;
   logic               csr_xfer;
   logic               geom_write;
   logic [GEOM_W-1:0]  mask;
   logic [GEOM_W-1:0]  ox, oy, out_w, out_h;
   logic               in_range;
   logic               s1_advance;
   logic               ram_wr_en;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic [ENTRY_W-1:0] old_sum;
   logic [ENTRY_W-1:0] new_sum;
   logic [SUM_W-1:0]   new_r, new_g, new_b;
   logic [GEOM_W:0]    col_next, row_next;
   req_payload_type    pix;

   assign csr_ready = !reset;
   assign csr_xfer  = csr_valid && csr_ready;

   // A result in the stage may leave only if the output register frees up.
   assign s1_advance = s1_valid_ff && (!s1_emit_ff || !out_valid_ff || !rsp_stall);
   assign req_stall  = reset || (s1_valid_ff && !s1_advance);
   assign req_xfer   = req_valid && !req_stall;

   // Configuration writes. Only the geometry registers move the scale.
   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      grey_in    = grey_ff;
      geom_write = 1'b0;
      if (csr_xfer) begin
         case (csr_index)
            CSR_SOURCE_WIDTH: begin
               width_in   = csr_data;
               geom_write = 1'b1;
            end
            CSR_SOURCE_HEIGHT: begin
               height_in  = csr_data;
               geom_write = 1'b1;
            end
            CSR_GREY_MODE: begin
               grey_in = csr_data[0];
            end
            default: begin
            end
         endcase
      end
      scale_in = geom_write ? pick_scale(width_in, height_in) : scale_ff;
   end

   // Block position of the incoming pixel.
   assign mask  = ~({GEOM_W{1'b1}} << scale_ff);
   assign ox    = col_ff >> scale_ff;
   assign oy    = row_ff >> scale_ff;
   assign out_w = width_ff >> scale_ff;
   assign out_h = height_ff >> scale_ff;
   assign in_range = (ox < out_w) && (oy < out_h) && ({1'b0, ox} < LIMIT_VAL);

   always_comb begin
      pix = req_payload;
      if (grey_ff) begin
         pix.green = req_payload.red;
         pix.blue  = req_payload.red;
      end
   end

   // Raster position. A geometry write restarts the frame.
   assign col_next = {1'b0, col_ff} + (GEOM_W + 1)'(1);
   assign row_next = {1'b0, row_ff} + (GEOM_W + 1)'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (geom_write) begin
         col_in = '0;
         row_in = '0;
      end else if (req_xfer) begin
         if (col_next >= {1'b0, width_ff}) begin
            col_in = '0;
            if (row_next >= {1'b0, height_ff}) begin
               row_in = '0;
            end else begin
               row_in = row_next[GEOM_W-1:0];
            end
         end else begin
            col_in = col_next[GEOM_W-1:0];
         end
      end
   end

   // Stage load. Pixels outside the kept area never enter the stage. When
   // the item now leaving writes the entry that the new pixel reads, the
   // RAM still returns the old sum, so the written sum is captured instead.
   always_comb begin
      s1_valid_in = s1_valid_ff && !s1_advance;
      s1_first_in = s1_first_ff;
      s1_emit_in  = s1_emit_ff;
      s1_last_in  = s1_last_ff;
      s1_fwd_in   = s1_fwd_ff;
      s1_addr_in  = s1_addr_ff;
      s1_pix_in   = s1_pix_ff;
      fwd_data_in = fwd_data_ff;
      if (req_xfer) begin
         s1_valid_in = in_range;
         s1_first_in = ((col_ff & mask) == '0) && ((row_ff & mask) == '0);
         s1_emit_in  = ((col_ff & mask) == mask) && ((row_ff & mask) == mask);
         s1_last_in  = ({1'b0, ox} + (GEOM_W + 1)'(1) == {1'b0, out_w}) &&
                       ({1'b0, oy} + (GEOM_W + 1)'(1) == {1'b0, out_h});
         s1_addr_in  = ox[ADDR_W-1:0];
         s1_pix_in   = pix;
         s1_fwd_in   = ram_wr_en && (s1_addr_ff == ox[ADDR_W-1:0]);
         fwd_data_in = new_sum;
      end
   end

   // Accumulate, or start a new block with the first pixel.
   assign old_sum = s1_fwd_ff ? fwd_data_ff : ram_rd_data;

   always_comb begin
      if (s1_first_ff) begin
         new_r = SUM_W'(s1_pix_ff.red);
         new_g = SUM_W'(s1_pix_ff.green);
         new_b = SUM_W'(s1_pix_ff.blue);
      end else begin
         new_r = old_sum[3*SUM_W-1:2*SUM_W] + SUM_W'(s1_pix_ff.red);
         new_g = old_sum[2*SUM_W-1:SUM_W]   + SUM_W'(s1_pix_ff.green);
         new_b = old_sum[SUM_W-1:0]         + SUM_W'(s1_pix_ff.blue);
      end
   end

   assign new_sum   = {new_r, new_g, new_b};
   assign ram_wr_en = s1_advance;

   // Output register. A finished block is averaged by a shift of twice the
   // scale; the result always fits in a byte.
   always_comb begin
      out_valid_in   = out_valid_ff && rsp_stall;
      out_payload_in = out_payload_ff;
      if (s1_advance && s1_emit_ff) begin
         out_valid_in              = 1'b1;
         out_payload_in.out_red    = PIX_W'(new_r >> {scale_ff, 1'b0});
         out_payload_in.out_green  = PIX_W'(new_g >> {scale_ff, 1'b0});
         out_payload_in.out_blue   = PIX_W'(new_b >> {scale_ff, 1'b0});
         out_payload_in.last_pixel = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= GEOM_W'(512);
         height_ff    <= GEOM_W'(512);
         grey_ff      <= 1'b0;
         scale_ff     <= pick_scale(GEOM_W'(512), GEOM_W'(512));
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         grey_ff      <= grey_in;
         scale_ff     <= scale_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff    <= s1_first_in;
      s1_emit_ff     <= s1_emit_in;
      s1_last_ff     <= s1_last_in;
      s1_fwd_ff      <= s1_fwd_in;
      s1_addr_ff     <= s1_addr_in;
      s1_pix_ff      <= s1_pix_in;
      fwd_data_ff    <= fwd_data_in;
      out_payload_ff <= out_payload_in;
   end

   // Line store of partial sums, one entry per output column.
   pbd_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(LIMIT_SIDE)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(s1_addr_ff),
      .wr_data(new_sum),
      .rd_en  (req_xfer),
      .rd_addr(ox[ADDR_W-1:0]),
      .rd_data(ram_rd_data)
   );

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_payload_ff;

endmodule

FILE: design/pbd_checker.sv
// ----------------------------------------------------------------------------
// Power-of-two box downsampler checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "power_of_two_box_downsampler_top_macros.svh"

module pbd_checker
   import pbd_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   // A stalled result holds.
   `PBD_ASSERT_IMPL(a_rsp_hold, rsp_valid && rsp_stall, ##1 (rsp_valid && $stable(rsp_payload)), "stalled result changed")

   // A new result follows the transfer of its last pixel through the stage and the output register.
   `PBD_ASSERT_IMPL(a_rsp_latency, $rose(rsp_valid), $past(req_valid && !req_stall, 2), "result without a matching pixel transfer")

   // The input stalls only in reset or behind a stalled result.
   `PBD_ASSERT_ALWAYS(a_stall_cause, req_stall, reset || (rsp_valid && rsp_stall), "input stalled without a stalled result")

   // Reset empties the output.
   `PBD_ASSERT_ALWAYS(a_reset_empty, $past(reset), !rsp_valid, "result present right after reset")

endmodule

bind power_of_two_box_downsampler_top pbd_checker u_pbd_checker (.*);
